FILE: rtl/lcdfb_pkg.sv
// Shared types, codes and the microcode program of the LCD frame buffer driver.
package lcdfb_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
    } cmd_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       is_data;
        logic       last_of_run;
        logic       frame_done;
    } res_t;

    typedef enum logic [1:0] {
        FUNC_PIXEL   = 2'd0,
        FUNC_REFRESH = 2'd1,
        FUNC_INIT    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [0:0] {
        REG_CONTRAST = 1'b0,
        REG_RATIO    = 1'b1
    } reg_idx_t;

    // Source of the byte placed on the result port.
    typedef enum logic [2:0] {
        SRC_CONST    = 3'd0,
        SRC_PAGE     = 3'd1,
        SRC_COL_LO   = 3'd2,
        SRC_COL_HI   = 3'd3,
        SRC_RAM      = 3'd4,
        SRC_RATIO    = 3'd5,
        SRC_CONTRAST = 3'd6
    } src_t;

    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] STEP_PIXEL   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_REFRESH = 5'd2;
    localparam logic [STEP_W-1:0] STEP_INIT    = 5'd6;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;
    localparam logic [7:0] CMD_RATIO     = 8'h20;

    localparam logic [5:0] CONTRAST_RESET = 6'd22;
    localparam logic [2:0] RATIO_RESET    = 3'd7;

    // One control word per microcode step.
    typedef struct packed {
        logic       emit;
        src_t       src;
        logic [7:0] cbyte;
        logic       is_data;
        logic       last;
        logic       use_done;
        logic       mem_rd;
        logic       mem_wr;
        logic       addr_pix;
        logic       adv;
        logic       stop;
        logic       stop_if_oor;
    } ctl_t;

    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t c;
        c = '0;
        c.src = SRC_CONST;
        case (step)
            // Set pixel: read the byte, then write it back with the new bit.
            5'd0:
            begin
                c.mem_rd      = 1'b1;
                c.addr_pix    = 1'b1;
                c.stop_if_oor = 1'b1;
            end
            5'd1:
            begin
                c.mem_wr   = 1'b1;
                c.addr_pix = 1'b1;
                c.stop     = 1'b1;
            end
            // Refresh one cell. The read issued here is consumed by the data step.
            5'd2:
            begin
                c.emit     = 1'b1;
                c.src      = SRC_PAGE;
                c.use_done = 1'b1;
                c.mem_rd   = 1'b1;
            end
            5'd3:
            begin
                c.emit     = 1'b1;
                c.src      = SRC_COL_LO;
                c.use_done = 1'b1;
            end
            5'd4:
            begin
                c.emit     = 1'b1;
                c.src      = SRC_COL_HI;
                c.use_done = 1'b1;
            end
            5'd5:
            begin
                c.emit     = 1'b1;
                c.src      = SRC_RAM;
                c.is_data  = 1'b1;
                c.last     = 1'b1;
                c.use_done = 1'b1;
                c.adv      = 1'b1;
                c.stop     = 1'b1;
            end
            // Initialization sequence.
            5'd6:  begin c.emit = 1'b1; c.cbyte = 8'h40; end
            5'd7:  begin c.emit = 1'b1; c.cbyte = 8'hA1; end
            5'd8:  begin c.emit = 1'b1; c.cbyte = 8'hC0; end
            5'd9:  begin c.emit = 1'b1; c.cbyte = 8'hA6; end
            5'd10: begin c.emit = 1'b1; c.cbyte = 8'hA2; end
            5'd11: begin c.emit = 1'b1; c.cbyte = 8'h2F; end
            5'd12: begin c.emit = 1'b1; c.cbyte = 8'hF8; end
            5'd13: begin c.emit = 1'b1; c.cbyte = 8'h00; end
            5'd14: begin c.emit = 1'b1; c.src = SRC_RATIO; end
            5'd15: begin c.emit = 1'b1; c.cbyte = 8'h81; end
            5'd16: begin c.emit = 1'b1; c.src = SRC_CONTRAST; end
            5'd17: begin c.emit = 1'b1; c.cbyte = 8'hAC; end
            5'd18: begin c.emit = 1'b1; c.cbyte = 8'h00; end
            5'd19:
            begin
                c.emit  = 1'b1;
                c.cbyte = 8'hAF;
                c.last  = 1'b1;
                c.stop  = 1'b1;
            end
            default:
            begin
                c.stop = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/lcdfb_ram.sv
// Generic single-port RAM with registered read data.
module lcdfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: rtl/lcd_framebuffer_refresh_driver_unit.sv
// Page-organized LCD frame buffer driver: microcoded sequencer around the frame store.
// The first result word is registered after start has moved the sequencer into ST_RUN;
// results then follow one per cycle. A refresh emits 4 words, init 14 words, a set-pixel none;
// busy goes low between commands, and a new command is taken only from idle.
// After reset the frame store's NUM_COLUMNS*NUM_PAGES entries are cleared at one entry per cycle,
// with busy high; configuration writes are taken throughout. The receiver cannot stall.
module lcd_framebuffer_refresh_driver_unit #(
    parameter int NUM_COLUMNS = 128,
    parameter int NUM_PAGES   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lcdfb_pkg::cmd_t   cmd,
    output logic              result_valid,
    output lcdfb_pkg::res_t   result,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [5:0]        cfg_data
);

    localparam int CELLS = NUM_COLUMNS * NUM_PAGES;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(NUM_COLUMNS);
    localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                          state_reg, state_next;
    logic [lcdfb_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic [CW-1:0]                   col_reg, col_next;
    logic [PW-1:0]                   page_reg, page_next;
    logic [AW-1:0]                   pix_addr_reg, pix_addr_next;
    logic [7:0]                      mask_reg, mask_next;
    logic                            pix_ok_reg, pix_ok_next;
    logic [5:0]                      contrast_reg, contrast_next;
    logic [2:0]                      ratio_reg, ratio_next;
    logic                            valid_reg, valid_next;
    lcdfb_pkg::res_t                 res_reg, res_next;

    lcdfb_pkg::ctl_t ctl;
    logic            running;
    logic            frame_last;
    logic [AW-1:0]   ref_addr;
    logic [7:0]      col_byte;
    logic [7:0]      byte_sel;
    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;

    lcdfb_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign running    = (state_reg == ST_RUN);
    assign ctl        = lcdfb_pkg::ucode(step_reg);
    assign frame_last = (col_reg == CW'(NUM_COLUMNS - 1)) && (page_reg == PW'(NUM_PAGES - 1));
    assign ref_addr   = AW'(int'(col_reg) * NUM_PAGES + int'(page_reg));
    assign col_byte   = 8'(col_reg);

    always_comb
    begin
        ram_we    = (state_reg == ST_CLEAR) || (running && ctl.mem_wr);
        ram_re    = running && ctl.mem_rd;
        ram_wdata = (state_reg == ST_CLEAR) ? 8'h00 : (ram_rdata | mask_reg);
        if (state_reg == ST_CLEAR)
        begin
            ram_addr = clr_addr_reg;
        end
        else if (ctl.addr_pix)
        begin
            ram_addr = pix_addr_reg;
        end
        else
        begin
            ram_addr = ref_addr;
        end
    end

    always_comb
    begin
        case (ctl.src)
            lcdfb_pkg::SRC_CONST:    byte_sel = ctl.cbyte;
            lcdfb_pkg::SRC_PAGE:     byte_sel = lcdfb_pkg::CMD_PAGE_BASE + 8'(page_reg);
            lcdfb_pkg::SRC_COL_LO:   byte_sel = {4'h0, col_byte[3:0]};
            lcdfb_pkg::SRC_COL_HI:   byte_sel = lcdfb_pkg::CMD_COL_HI | {4'h0, col_byte[7:4]};
            lcdfb_pkg::SRC_RAM:      byte_sel = ram_rdata;
            lcdfb_pkg::SRC_RATIO:    byte_sel = lcdfb_pkg::CMD_RATIO | {5'd0, ratio_reg};
            lcdfb_pkg::SRC_CONTRAST: byte_sel = {2'b00, contrast_reg};
            default:                 byte_sel = ctl.cbyte;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        clr_addr_next = clr_addr_reg;
        col_next      = col_reg;
        page_next     = page_reg;
        pix_addr_next = pix_addr_reg;
        mask_next     = mask_reg;
        pix_ok_next   = pix_ok_reg;
        contrast_next = contrast_reg;
        ratio_next    = ratio_reg;
        valid_next    = 1'b0;
        res_next      = res_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                lcdfb_pkg::REG_CONTRAST: contrast_next = cfg_data;
                lcdfb_pkg::REG_RATIO:    ratio_next    = cfg_data[2:0];
                default:                 contrast_next = contrast_reg;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    pix_addr_next = AW'(int'(cmd.pixel_x) * NUM_PAGES + int'(cmd.pixel_y[5:3]));
                    mask_next     = 8'h01 << cmd.pixel_y[2:0];
                    pix_ok_next   = (int'(cmd.pixel_x) < NUM_COLUMNS)
                                    && (int'(cmd.pixel_y[5:3]) < NUM_PAGES);
                    case (cmd.func)
                        lcdfb_pkg::FUNC_PIXEL:
                        begin
                            step_next  = lcdfb_pkg::STEP_PIXEL;
                            state_next = ST_RUN;
                        end
                        lcdfb_pkg::FUNC_REFRESH:
                        begin
                            step_next  = lcdfb_pkg::STEP_REFRESH;
                            state_next = ST_RUN;
                        end
                        lcdfb_pkg::FUNC_INIT:
                        begin
                            step_next  = lcdfb_pkg::STEP_INIT;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + lcdfb_pkg::STEP_W'(1);
                if (ctl.stop || (ctl.stop_if_oor && !pix_ok_reg))
                begin
                    state_next = ST_IDLE;
                end
                if (ctl.emit)
                begin
                    valid_next           = 1'b1;
                    res_next.tx_byte     = byte_sel;
                    res_next.is_data     = ctl.is_data;
                    res_next.last_of_run = ctl.last;
                    res_next.frame_done  = ctl.use_done && frame_last;
                end
                // Column-major walk with the page as the inner index.
                if (ctl.adv)
                begin
                    if (page_reg == PW'(NUM_PAGES - 1))
                    begin
                        page_next = '0;
                        col_next  = frame_last ? '0 : col_reg + CW'(1);
                    end
                    else
                    begin
                        page_next = page_reg + PW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            step_reg     <= '0;
            clr_addr_reg <= '0;
            col_reg      <= '0;
            page_reg     <= '0;
            pix_addr_reg <= '0;
            mask_reg     <= '0;
            pix_ok_reg   <= 1'b0;
            contrast_reg <= lcdfb_pkg::CONTRAST_RESET;
            ratio_reg    <= lcdfb_pkg::RATIO_RESET;
            valid_reg    <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            clr_addr_reg <= clr_addr_next;
            col_reg      <= col_next;
            page_reg     <= page_next;
            pix_addr_reg <= pix_addr_next;
            mask_reg     <= mask_next;
            pix_ok_reg   <= pix_ok_next;
            contrast_reg <= contrast_next;
            ratio_reg    <= ratio_next;
            valid_reg    <= valid_next;
            res_reg      <= res_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

FILE: tb/lcdfb_checker.sv
// Checker that predicts the LCD driver's output words and compares them as they appear.
module lcdfb_checker
    import lcdfb_pkg::*;
#(
    parameter int NUM_COLUMNS = 128,
    parameter int NUM_PAGES   = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  cmd_t       cmd,
    input  logic       result_valid,
    input  res_t       result,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [5:0] cfg_data,
    output int         mismatches,
    output int         words_due
);

    localparam int CELLS = NUM_COLUMNS * NUM_PAGES;

    logic [7:0] shadow_frame [CELLS];
    int         scan_cell;
    logic [5:0] contrast;
    logic [2:0] ratio;
    res_t       due_words [$];
    res_t       oldest;
    int         bad;

    task automatic compare(input string what, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            bad++;
        end
    endtask

    // Updates the shadow state for one command and queues the words it should produce.
    task automatic queue_words_for(input cmd_t c);
        res_t w;
        int   col;
        int   page;
        int   cell_idx;
        logic hit_end;
        w = '0;
        case (func_t'(c.func))
            FUNC_PIXEL:
            begin
                page = int'(c.pixel_y) / 8;
                if (int'(c.pixel_x) < NUM_COLUMNS && page < NUM_PAGES)
                begin
                    cell_idx = int'(c.pixel_x) * NUM_PAGES + page;
                    shadow_frame[cell_idx][c.pixel_y[2:0]] = 1'b1;
                end
            end
            FUNC_REFRESH:
            begin
                page = scan_cell % NUM_PAGES;
                col = scan_cell / NUM_PAGES;
                hit_end = (scan_cell == CELLS - 1);
                w.frame_done = hit_end;
                w.tx_byte = CMD_PAGE_BASE + 8'(page);
                due_words.push_back(w);
                w.tx_byte = 8'(col & 15);
                due_words.push_back(w);
                w.tx_byte = CMD_COL_HI | 8'((col >> 4) & 15);
                due_words.push_back(w);
                w.tx_byte = shadow_frame[scan_cell];
                w.is_data = 1'b1;
                w.last_of_run = 1'b1;
                due_words.push_back(w);
                scan_cell = hit_end ? 0 : scan_cell + 1;
            end
            FUNC_INIT:
            begin
                for (int i = 0; i < 14; i++)
                begin
                    case (i)
                        0:       w.tx_byte = 8'h40;
                        1:       w.tx_byte = 8'hA1;
                        2:       w.tx_byte = 8'hC0;
                        3:       w.tx_byte = 8'hA6;
                        4:       w.tx_byte = 8'hA2;
                        5:       w.tx_byte = 8'h2F;
                        6:       w.tx_byte = 8'hF8;
                        8:       w.tx_byte = CMD_RATIO + 8'(ratio);
                        9:       w.tx_byte = 8'h81;
                        10:      w.tx_byte = 8'(contrast);
                        11:      w.tx_byte = 8'hAC;
                        13:      w.tx_byte = 8'hAF;
                        default: w.tx_byte = 8'h00;
                    endcase
                    w.last_of_run = (i == 13);
                    due_words.push_back(w);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CELLS; k++)
                shadow_frame[k] = '0;
            due_words.delete();
            scan_cell = 0;
            contrast = CONTRAST_RESET;
            ratio = RATIO_RESET;
            bad = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (due_words.size() == 0)
                begin
                    $display("%0t: word expected none, got %h", $time, result);
                    bad++;
                end
                else
                begin
                    oldest = due_words.pop_front();
                    compare("tx_byte", result.tx_byte, oldest.tx_byte);
                    compare("is_data", 8'(result.is_data), 8'(oldest.is_data));
                    compare("last_of_run", 8'(result.last_of_run), 8'(oldest.last_of_run));
                    compare("frame_done", 8'(result.frame_done), 8'(oldest.frame_done));
                end
            end
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_CONTRAST: contrast = cfg_data;
                    REG_RATIO:    ratio = cfg_data[2:0];
                endcase
            end
            if (start && !busy)
                queue_words_for(cmd);
        end
        mismatches <= bad;
        words_due <= due_words.size();
    end

endmodule

FILE: tb/tb.sv
// Top of the LCD driver testbench: clock, reset, command stimulus and the verdict.
module tb;
    import lcdfb_pkg::*;

    localparam int NUM_COLUMNS = 128;
    localparam int NUM_PAGES   = 8;
    localparam int CELLS       = NUM_COLUMNS * NUM_PAGES;
    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    cmd_t       cmd = '0;
    logic       result_valid;
    res_t       result;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_CONTRAST;
    logic [5:0] cfg_data = '0;
    int         mismatches;
    int         words_due;
    int         cycles;
    int         gap_pct = 15;

    lcd_framebuffer_refresh_driver_unit #(
        .NUM_COLUMNS(NUM_COLUMNS),
        .NUM_PAGES  (NUM_PAGES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .result_valid(result_valid),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    lcdfb_checker #(
        .NUM_COLUMNS(NUM_COLUMNS),
        .NUM_PAGES  (NUM_PAGES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .result_valid(result_valid),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .words_due   (words_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Start stays high from one accepted command into the next unless a gap is drawn.
    task automatic send(input func_t f, input logic [6:0] x, input logic [5:0] y);
        cmd_t c;
        c.func = f;
        c.pixel_x = x;
        c.pixel_y = y;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_regs(input logic [5:0] contrast_val, input logic [5:0] ratio_val);
        cfg_we <= 1'b1;
        cfg_index <= REG_CONTRAST;
        cfg_data <= contrast_val;
        @(posedge clk);
        cfg_index <= REG_RATIO;
        cfg_data <= ratio_val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Holds commands off until every predicted word is back and the block is idle.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (words_due != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int         r;
        func_t      f;
        logic [6:0] x;
        logic [5:0] y;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Init with the reset register values, then corner pixels and the first cells.
        send(FUNC_INIT, 7'd0, 6'd0);
        send(FUNC_PIXEL, 7'd0, 6'd0);
        send(FUNC_PIXEL, 7'd127, 6'd63);
        send(FUNC_PIXEL, 7'd0, 6'd63);
        send(FUNC_PIXEL, 7'd127, 6'd0);
        send(FUNC_PIXEL, 7'd0, 6'd9);
        send(FUNC_PIXEL, 7'd0, 6'd8);
        send(FUNC_PIXEL, 7'd0, 6'd0);
        send(FUNC_NONE, 7'd127, 6'd63);
        send(FUNC_REFRESH, 7'd127, 6'd63);
        send(FUNC_REFRESH, 7'd0, 6'd0);
        send(FUNC_REFRESH, 7'd85, 6'd42);
        settle();
        // Ratio data with the upper bits set must keep only the low three.
        write_regs(6'd63, 6'h38);
        send(FUNC_INIT, 7'd127, 6'd63);
        settle();
        write_regs(6'd0, 6'h07);
        send(FUNC_INIT, 7'd42, 6'd21);
        send(FUNC_NONE, 7'd0, 6'd0);
        settle();

        for (int i = 0; i < 140; i++)
        begin
            gap_pct = (i >= 40 && i < 90) ? 0 : 15;
            if (i == 70)
            begin
                settle();
                write_regs(6'($urandom_range(63)), 6'($urandom_range(63)));
            end
            if (i == 110)
                settle();
            r = $urandom_range(99);
            f = r < 45 ? FUNC_PIXEL : r < 80 ? FUNC_REFRESH : r < 90 ? FUNC_INIT : FUNC_NONE;
            // Half the pixels land in the first columns, where the refresh pointer still is.
            x = $urandom_range(1) ? 7'($urandom_range(7)) : 7'($urandom);
            y = 6'($urandom);
            send(f, x, y);
        end

        // Read back a further run of cells after the random traffic.
        settle();
        for (int i = 0; i < 24; i++)
            send(FUNC_REFRESH, 7'($urandom), 6'($urandom));
        settle();
        write_regs(6'($urandom_range(63)), 6'($urandom_range(63)));
        send(FUNC_INIT, 7'($urandom), 6'($urandom));
        settle();

        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lcdfb_pkg.sv
rtl/lcdfb_ram.sv
rtl/lcd_framebuffer_refresh_driver_unit.sv
tb/lcdfb_checker.sv
tb/tb.sv
